@@ hw/rtl/wc2d_pkg.sv @@
package wc2d_pkg;

    localparam int PIX_W  = 16;
    localparam int KROW_W = 48;
    localparam int PROD_W = 2 * PIX_W;
    localparam int ROWS_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;
    localparam int FRAC_W = 14;
    localparam int ROW_W  = 14;
    localparam int WID_W  = 12;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

    localparam logic [10:0]       LINE_WIDTH_RST   = 11'd1024;
    localparam logic [11:0]       FRAME_HEIGHT_RST = 12'd1024;
    localparam logic [KROW_W-1:0] KERNEL_MID_RST   = 48'h0000_4000_0000;

    typedef logic signed [PIX_W-1:0] pix_t;
    typedef pix_t [8:0] win_t;
    typedef logic [2:0][KROW_W-1:0] kernel_t;

    typedef struct packed {
        logic valid;
        logic border;
        logic last;
    } tag_t;

endpackage

@@ hw/rtl/wc2d_mac.sv @@
module wc2d_mac
    import wc2d_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  tag_t    in_tag,
    input  pix_t    in_centre,
    input  win_t    in_win,
    input  kernel_t kernel,
    output tag_t    out_tag,
    output pix_t    out_pixel
);

    logic signed [PROD_W-1:0] prod_reg [9];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [ROWS_W-1:0] rsum_reg [3];
    logic signed [ROWS_W-1:0] rsum_next [3];
    tag_t tag_a_reg, tag_b_reg;
    pix_t centre_a_reg, centre_b_reg;

    logic signed [SUM_W-1:0]        total;
    logic signed [SUM_W-FRAC_W-1:0] scaled;
    pix_t                           sat;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r*3+c] = PROD_W'($signed(in_win[r*3+c]))
                                 * PROD_W'($signed(kernel[r][c*PIX_W +: PIX_W]));
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            rsum_next[r] = ROWS_W'(prod_reg[r*3]) + ROWS_W'(prod_reg[r*3+1])
                         + ROWS_W'(prod_reg[r*3+2]);
        end
    end

    // floor by arithmetic shift, then clamp to 16 bits
    always_comb begin
        total  = SUM_W'(rsum_reg[0]) + SUM_W'(rsum_reg[1]) + SUM_W'(rsum_reg[2]);
        scaled = total[SUM_W-1:FRAC_W];
        if (scaled > (SUM_W-FRAC_W)'(32767)) begin
            sat = 16'sh7fff;
        end else if (scaled < -(SUM_W-FRAC_W)'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = scaled[PIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end else if (en) begin
            tag_a_reg <= in_tag;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg     <= prod_next;
            rsum_reg     <= rsum_next;
            centre_a_reg <= in_centre;
            centre_b_reg <= centre_a_reg;
        end
    end

    assign out_tag   = tag_b_reg;
    assign out_pixel = tag_b_reg.border ? centre_b_reg : sat;

endmodule

@@ hw/rtl/window_convolution_2d_top.sv @@
// Channel | Direction | Beat contents
// s_      | in        | tdata[15:0] pixel_in; tuser[0] flush
// m_      | out       | tdata[15:0] pixel_out; tlast last_in_frame
// cfg_    | in        | cfg_index register number, cfg_data value (ready out of reset)
//
// One pixel a clock while m_ is not back-pressured; a result is valid on m_ once
// its beat has passed stage-1, MAC and output registers. The line store is one
// two-row-wide RAM, read and written once a cycle, with a bypass for a column
// hit twice in a row. Back-pressure on m_ stalls the whole pipe; s_tready
// follows the output slot. aresetn is synchronous; the line store is not cleared.
module window_convolution_2d_top
    import wc2d_pkg::*;
#(
    parameter int MAX_LINE = 1024,
    parameter int WINDOW   = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] pixel_in
    input  logic                 s_tuser,   // [0] flush
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] pixel_out
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KROW_W-1:0]    cfg_data
);

    localparam bit OFF = (WINDOW / 2) > 0;
    localparam int CW  = $clog2(MAX_LINE);
    localparam logic [WID_W:0] MAXW = (WID_W+1)'(MAX_LINE);

    logic [10:0]       line_width_reg;
    logic [11:0]       frame_height_reg;
    kernel_t           kernel_reg;

    logic [ROW_W-1:0]  row_reg;
    logic [CW-1:0]     col_reg;

    logic              s1_valid_reg, s1_border_reg, s1_last_reg, s1_emit_reg;
    logic [CW-1:0]     s1_col_reg;
    pix_t              s1_x_reg;
    win_t              win_reg;
    logic [31:0]       mem [MAX_LINE];
    logic [31:0]       rd_reg;
    logic [31:0]       byp_data_reg;
    logic              byp_reg;

    logic              m_valid_reg, m_last_reg;
    pix_t              m_pixel_reg;

    logic              en, accept, cfg_we;
    logic [WID_W-1:0]  w;
    logic [ROW_W-1:0]  h;
    logic [10:0]       lw_min;

    logic [ROW_W-1:0]  row_n, row_s, orow;
    logic [WID_W-1:0]  col_n, col_s, ocol;
    logic              beyond, in_frame, ignore, emit, border, last, step;
    pix_t              x;
    logic [CW-1:0]     rd_col;

    logic [31:0]       rd_data;
    pix_t              top_px, mid_px;
    win_t              win_next;
    tag_t              s1_tag, mac_tag;
    pix_t              mac_pixel;

    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en && aresetn;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = aresetn;
    assign cfg_we    = cfg_valid && cfg_ready;

    // effective frame size
    always_comb begin
        lw_min = (line_width_reg < 11'd3) ? 11'd3 : line_width_reg;
        w = ((WID_W+1)'(lw_min) > MAXW) ? WID_W'(MAX_LINE) : WID_W'(lw_min);
        h = (frame_height_reg < 12'd3) ? ROW_W'(3) : ROW_W'(frame_height_reg);
    end

    // raster position, output position and next position of the beat at s_
    always_comb begin
        row_n = row_reg;
        col_n = WID_W'(col_reg);
        if (col_n >= w) begin
            col_n = '0;
            row_n = row_reg + 1'b1;
        end
        if (OFF) begin
            beyond = (row_n > h + 1'b1) || (row_n == h + 1'b1 && col_n != '0);
        end else begin
            beyond = row_n >= h;
        end
        if (beyond) begin
            row_n = '0;
            col_n = '0;
        end
        in_frame = row_n < h;
        ignore   = s_tuser && in_frame;
        x        = (!s_tuser && in_frame) ? $signed(s_tdata) : '0;

        if (OFF) begin
            emit = (row_n >= ROW_W'(2)) || (row_n == ROW_W'(1) && col_n != '0);
            if (col_n != '0) begin
                orow = row_n - ROW_W'(1);
                ocol = col_n - WID_W'(1);
            end else begin
                orow = row_n - ROW_W'(2);
                ocol = w - WID_W'(1);
            end
        end else begin
            emit = 1'b1;
            orow = row_n;
            ocol = col_n;
        end
        border = OFF && (orow == '0 || orow == h - 1'b1 || ocol == '0 || ocol == w - 1'b1);
        last   = (orow == h - 1'b1) && (ocol == w - 1'b1);

        col_s = col_n + 1'b1;
        row_s = row_n;
        if (col_s >= w) begin
            col_s = '0;
            row_s = row_n + 1'b1;
        end
        if (emit && last) begin
            col_s = '0;
            row_s = '0;
        end
        step   = accept && !ignore;
        rd_col = CW'(col_n);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            kernel_reg       <= {48'd0, KERNEL_MID_RST, 48'd0};
        end else if (cfg_we) begin
            case (cfg_index)
                REG_LINE_WIDTH:    line_width_reg   <= cfg_data[10:0];
                REG_FRAME_HEIGHT:  frame_height_reg <= cfg_data[11:0];
                REG_KERNEL_TOP:    kernel_reg[0]    <= cfg_data;
                REG_KERNEL_MIDDLE: kernel_reg[1]    <= cfg_data;
                REG_KERNEL_BOTTOM: kernel_reg[2]    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end else if (en) begin
            if (accept) begin
                row_reg <= ignore ? row_n : row_s;
                col_reg <= ignore ? CW'(col_n) : CW'(col_s);
            end
            s1_valid_reg <= step;
            byp_reg      <= OFF && step && s1_valid_reg && (s1_col_reg == rd_col);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_emit_reg   <= emit;
            s1_border_reg <= border;
            s1_last_reg   <= last;
            s1_col_reg    <= rd_col;
            s1_x_reg      <= x;
        end
    end

    // line store: [31:16] row two above, [15:0] previous row
    assign rd_data = byp_reg ? byp_data_reg : rd_reg;
    assign top_px  = rd_data[31:16];
    assign mid_px  = rd_data[15:0];

    always_ff @(posedge aclk) begin
        if (OFF && en) begin
            rd_reg       <= mem[rd_col];
            byp_data_reg <= {mid_px, s1_x_reg};
            if (s1_valid_reg) begin
                mem[s1_col_reg] <= {mid_px, s1_x_reg};
            end
        end
    end

    always_comb begin
        win_next = '0;
        if (OFF) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r*3]   = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
            win_next[2] = top_px;
            win_next[5] = mid_px;
            win_next[8] = s1_x_reg;
        end else begin
            win_next[4] = s1_x_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (en && s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    assign s1_tag.valid  = s1_valid_reg && s1_emit_reg;
    assign s1_tag.border = s1_border_reg;
    assign s1_tag.last   = s1_last_reg;

    wc2d_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_tag    (s1_tag),
        .in_centre (win_next[4]),
        .in_win    (win_next),
        .kernel    (kernel_reg),
        .out_tag   (mac_tag),
        .out_pixel (mac_pixel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mac_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_pixel_reg <= mac_pixel;
            m_last_reg  <= mac_tag.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pixel_reg;
    assign m_tlast  = m_last_reg;

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !ignore && emit && last) |=> (row_reg == '0 && col_reg == '0))
        else $error("position not cleared after last output");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_we) |=> (WID_W'(col_reg) < w))
        else $error("column beyond line width");

    a_bypass_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        byp_reg |-> s1_valid_reg)
        else $error("line store bypass without item");

endmodule
